// ===== design/bresenham_line_pixel_generator_top_macros.svh =====
// Assertion helpers shared by the line generator modules.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define BLPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define BLPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BLPG_ASSERT(lbl, prop, msg)
`define BLPG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/blpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blpg_pkg;

  localparam int X_BITS      = 9;
  localparam int Y_BITS      = 8;
  // Coordinates along either axis share one width.
  localparam int C_BITS      = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  // The error term runs between minus the major delta and the major delta.
  localparam int E_BITS      = C_BITS + 2;
  localparam int COLOUR_BITS = 16;
  localparam int ADDR_BITS   = 32;
  localparam int ROW_SHIFT   = 10;
  localparam int COL_SHIFT   = 1;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic                   is_start;
    logic                   steep;
    logic [C_BITS-1:0]      major_pos;
    logic [C_BITS-1:0]      major_stop;
    logic [C_BITS-1:0]      minor_pos;
    logic                   minor_down;
    logic [C_BITS-1:0]      major_delta;
    logic [C_BITS-1:0]      minor_delta;
    logic [COLOUR_BITS-1:0] colour;
  } line_cmd_t;

  function automatic logic [C_BITS-1:0] abs_diff(input logic [C_BITS-1:0] a,
                                                 input logic [C_BITS-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/blpg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blpg_front (
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic [blpg_pkg::X_BITS-1:0]        x_begin_i,
  input  wire logic [blpg_pkg::Y_BITS-1:0]        y_begin_i,
  input  wire logic [blpg_pkg::X_BITS-1:0]        x_end_i,
  input  wire logic [blpg_pkg::Y_BITS-1:0]        y_end_i,
  input  wire logic [blpg_pkg::COLOUR_BITS-1:0]   pen_colour_i,
  input  wire logic                               q_full_i,
  output logic                                    q_push_o,
  output blpg_pkg::line_cmd_t                     q_cmd_o
);

  logic [blpg_pkg::C_BITS-1:0] x0, y0, x1, y1;
  logic [blpg_pkg::C_BITS-1:0] dx, dy;
  logic [blpg_pkg::C_BITS-1:0] a0, a1, b0, b1;
  logic [blpg_pkg::C_BITS-1:0] maj_lo, maj_hi, min_lo, min_hi;
  logic                        steep;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    x0 = blpg_pkg::C_BITS'(x_begin_i);
    y0 = blpg_pkg::C_BITS'(y_begin_i);
    x1 = blpg_pkg::C_BITS'(x_end_i);
    y1 = blpg_pkg::C_BITS'(y_end_i);
    dx = blpg_pkg::abs_diff(x1, x0);
    dy = blpg_pkg::abs_diff(y1, y0);
    // Equal deltas keep x as the major axis.
    steep = dy > dx;
    a0 = steep ? y0 : x0;
    a1 = steep ? y1 : x1;
    b0 = steep ? x0 : y0;
    b1 = steep ? x1 : y1;
    // Walk the major axis upwards, so swap the endpoints where needed.
    if (a0 > a1) begin
      maj_lo = a1;
      maj_hi = a0;
      min_lo = b1;
      min_hi = b0;
    end else begin
      maj_lo = a0;
      maj_hi = a1;
      min_lo = b0;
      min_hi = b1;
    end

    q_cmd_o.is_start    = (req_type_i == blpg_pkg::REQ_START);
    q_cmd_o.steep       = steep;
    q_cmd_o.major_pos   = maj_lo;
    q_cmd_o.major_stop  = maj_hi;
    q_cmd_o.minor_pos   = min_lo;
    q_cmd_o.minor_down  = !(min_lo < min_hi);
    q_cmd_o.major_delta = maj_hi - maj_lo;
    q_cmd_o.minor_delta = blpg_pkg::abs_diff(min_hi, min_lo);
    q_cmd_o.colour      = pen_colour_i;
  end

endmodule

`default_nettype wire

// ===== design/blpg_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bresenham_line_pixel_generator_top_macros.svh"

module blpg_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire blpg_pkg::line_cmd_t push_cmd_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output blpg_pkg::line_cmd_t      pop_cmd_o
);

  blpg_pkg::line_cmd_t                mem_q [blpg_pkg::Q_DEPTH];
  logic [blpg_pkg::Q_PTR_BITS-1:0]    wr_ptr_q, wr_ptr_d;
  logic [blpg_pkg::Q_PTR_BITS-1:0]    rd_ptr_q, rd_ptr_d;
  logic [blpg_pkg::Q_CNT_BITS-1:0]    cnt_q, cnt_d;
  logic                               do_push, do_pop;

  function automatic logic [blpg_pkg::Q_PTR_BITS-1:0] ptr_inc(
      input logic [blpg_pkg::Q_PTR_BITS-1:0] p);
    if (p == blpg_pkg::Q_PTR_BITS'(blpg_pkg::Q_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  assign full_o    = (cnt_q == blpg_pkg::Q_CNT_BITS'(blpg_pkg::Q_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `BLPG_ASSERT(a_cnt_bounded, cnt_q <= blpg_pkg::Q_CNT_BITS'(blpg_pkg::Q_DEPTH), "queue count above depth")
  `BLPG_ASSERT(a_pop_nonempty, pop_i |-> valid_o, "queue popped while empty")
  `BLPG_ASSERT(a_push_room, push_i |-> !full_o, "queue pushed while full")

endmodule

`default_nettype wire

// ===== design/blpg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bresenham_line_pixel_generator_top_macros.svh"

module blpg_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [blpg_pkg::ADDR_BITS-1:0]     cfg_wdata_i,
  input  wire logic                               q_valid_i,
  input  wire blpg_pkg::line_cmd_t                q_cmd_i,
  output logic                                    q_pop_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [blpg_pkg::X_BITS-1:0]             pix_x_o,
  output logic [blpg_pkg::Y_BITS-1:0]             pix_y_o,
  output logic [blpg_pkg::COLOUR_BITS-1:0]        pix_colour_o,
  output logic [blpg_pkg::ADDR_BITS-1:0]          pix_addr_o,
  output logic                                    last_pixel_o
);

  logic [blpg_pkg::ADDR_BITS-1:0]   base_q;
  logic                             active_q, active_d;
  logic                             steep_q, steep_d;
  logic [blpg_pkg::C_BITS-1:0]      major_pos_q, major_pos_d;
  logic [blpg_pkg::C_BITS-1:0]      major_stop_q, major_stop_d;
  logic [blpg_pkg::C_BITS-1:0]      minor_pos_q, minor_pos_d;
  logic                             minor_down_q, minor_down_d;
  logic [blpg_pkg::C_BITS-1:0]      major_delta_q, major_delta_d;
  logic [blpg_pkg::C_BITS-1:0]      minor_delta_q, minor_delta_d;
  logic signed [blpg_pkg::E_BITS-1:0] err_q, err_d, err_sum;
  logic [blpg_pkg::COLOUR_BITS-1:0] colour_q, colour_d;

  logic                             out_valid_q, out_valid_d;
  logic [blpg_pkg::X_BITS-1:0]      pix_x_q;
  logic [blpg_pkg::Y_BITS-1:0]      pix_y_q;
  logic [blpg_pkg::COLOUR_BITS-1:0] pix_colour_q;
  logic [blpg_pkg::ADDR_BITS-1:0]   pix_addr_q;
  logic                             last_q;

  logic                             can_load, need_out, emit, is_last;
  logic [blpg_pkg::X_BITS-1:0]      px;
  logic [blpg_pkg::Y_BITS-1:0]      py;
  logic [blpg_pkg::ADDR_BITS-1:0]   addr;

  // The output register takes a new word when empty or when its old one leaves that cycle.
  assign can_load = !out_valid_q || !out_stall_i;
  assign need_out = !q_cmd_i.is_start && active_q;
  assign q_pop_o  = q_valid_i && (!need_out || can_load);
  assign emit     = q_pop_o && need_out;
  assign is_last  = (major_pos_q == major_stop_q);

  always_comb begin
    if (steep_q) begin
      px = blpg_pkg::X_BITS'(minor_pos_q);
      py = blpg_pkg::Y_BITS'(major_pos_q);
    end else begin
      px = blpg_pkg::X_BITS'(major_pos_q);
      py = blpg_pkg::Y_BITS'(minor_pos_q);
    end
    addr = base_q + (blpg_pkg::ADDR_BITS'(py) << blpg_pkg::ROW_SHIFT)
                  + (blpg_pkg::ADDR_BITS'(px) << blpg_pkg::COL_SHIFT);
  end

  always_comb begin
    active_d      = active_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    major_stop_d  = major_stop_q;
    minor_pos_d   = minor_pos_q;
    minor_down_d  = minor_down_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    err_d         = err_q;
    colour_d      = colour_q;
    err_sum       = err_q + $signed({2'b00, minor_delta_q});

    if (q_pop_o && q_cmd_i.is_start) begin
      // A new line drops whatever was in progress.
      active_d      = 1'b1;
      steep_d       = q_cmd_i.steep;
      major_pos_d   = q_cmd_i.major_pos;
      major_stop_d  = q_cmd_i.major_stop;
      minor_pos_d   = q_cmd_i.minor_pos;
      minor_down_d  = q_cmd_i.minor_down;
      major_delta_d = q_cmd_i.major_delta;
      minor_delta_d = q_cmd_i.minor_delta;
      err_d         = blpg_pkg::E_BITS'(0) - {2'b00, (q_cmd_i.major_delta >> 1)};
      colour_d      = q_cmd_i.colour;
    end else if (emit) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        err_d = err_sum;
        if (err_sum >= 0) begin
          minor_pos_d = minor_down_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
          err_d       = err_sum - $signed({2'b00, major_delta_q});
        end
        major_pos_d = major_pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q       <= steep_d;
    major_pos_q   <= major_pos_d;
    major_stop_q  <= major_stop_d;
    minor_pos_q   <= minor_pos_d;
    minor_down_q  <= minor_down_d;
    major_delta_q <= major_delta_d;
    minor_delta_q <= minor_delta_d;
    err_q         <= err_d;
    colour_q      <= colour_d;
    if (emit) begin
      pix_x_q      <= px;
      pix_y_q      <= py;
      pix_colour_q <= colour_q;
      pix_addr_q   <= addr;
      last_q       <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pix_x_o      = pix_x_q;
  assign pix_y_o      = pix_y_q;
  assign pix_colour_o = pix_colour_q;
  assign pix_addr_o   = pix_addr_q;
  assign last_pixel_o = last_q;

  `BLPG_ASSERT(a_pos_in_range, active_q |-> (major_pos_q <= major_stop_q), "major position passed the stop")
  `BLPG_ASSERT(a_last_idles, (emit && is_last) |=> !active_q, "line still active after its last pixel")
  `BLPG_ASSERT(a_emit_shows, emit |=> out_valid_q, "emitted pixel did not reach the output")

endmodule

`default_nettype wire

// ===== design/bresenham_line_pixel_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   req_type, endpoints, pen_colour
// out       output     out_valid_o / out_stall_i pix_x, pix_y, pix_colour, pix_addr, last_pixel
// cfg       input      cfg_we_i                  buffer_base
//
// One word is accepted per cycle unless the queue is full; a step word passes the queue, its
// pixel the output register. The pixel stepper does one add-compare update per cycle, giving
// one pixel per clock while the output does not stall. A two-word queue sits between setup
// and stepper, so an output stall reaches the input only once the queue has filled. Reset
// is asynchronous and active low, and clears the queue, the line state and buffer_base.

module bresenham_line_pixel_generator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [blpg_pkg::ADDR_BITS-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic [blpg_pkg::X_BITS-1:0]        x_begin_i,
  input  wire logic [blpg_pkg::Y_BITS-1:0]        y_begin_i,
  input  wire logic [blpg_pkg::X_BITS-1:0]        x_end_i,
  input  wire logic [blpg_pkg::Y_BITS-1:0]        y_end_i,
  input  wire logic [blpg_pkg::COLOUR_BITS-1:0]   pen_colour_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [blpg_pkg::X_BITS-1:0]             pix_x_o,
  output logic [blpg_pkg::Y_BITS-1:0]             pix_y_o,
  output logic [blpg_pkg::COLOUR_BITS-1:0]        pix_colour_o,
  output logic [blpg_pkg::ADDR_BITS-1:0]          pix_addr_o,
  output logic                                    last_pixel_o
);

  logic                q_full, q_push, q_valid, q_pop;
  blpg_pkg::line_cmd_t push_cmd, pop_cmd;

  blpg_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .x_begin_i    (x_begin_i),
    .y_begin_i    (y_begin_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pen_colour_i (pen_colour_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  blpg_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd)
  );

  blpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pix_x_o      (pix_x_o),
    .pix_y_o      (pix_y_o),
    .pix_colour_o (pix_colour_o),
    .pix_addr_o   (pix_addr_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire
